FILE: rtl/core/sorted_priority_queue_core_macros.svh
// Assertion macros shared by the sorted priority queue checker.
// No dependencies; included by bare file name.
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");

`endif

FILE: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; used by the cell, the top level and the checker.
`default_nettype none

package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int KEY_W   = 32;
   localparam int PAY_W   = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT    = 3'd0,
      OP_POP_FRONT = 3'd1,
      OP_POP_BACK  = 3'd2,
      OP_REMOVE    = 3'd3,
      OP_FIND      = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // broadcast to every cell for one transfer
   typedef struct packed {
      logic             ins_en;
      logic             del_en;
      logic [IDX_W-1:0] del_pos;
   } cell_ctrl_type;

   // per-cell compare results against the incoming key
   typedef struct packed {
      logic after;
      logic equal;
   } cell_flag_type;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// One slot of the sorted list: holds a key and payload, compares against the
// incoming key and shifts from either neighbour. Depends on spq_pkg.
`default_nettype none

module spq_cell (
   input  wire logic                        clock,
   input  wire logic [spq_pkg::IDX_W-1:0]   cell_index,
   input  wire logic [spq_pkg::CNT_W-1:0]   occupancy,
   input  wire logic                        sort_descending,
   input  wire spq_pkg::cell_ctrl_type      ctrl,
   input  wire logic                        left_after,
   input  wire logic [spq_pkg::KEY_W-1:0]   new_key,
   input  wire logic [spq_pkg::PAY_W-1:0]   new_payload,
   input  wire logic [spq_pkg::KEY_W-1:0]   left_key,
   input  wire logic [spq_pkg::PAY_W-1:0]   left_payload,
   input  wire logic [spq_pkg::KEY_W-1:0]   right_key,
   input  wire logic [spq_pkg::PAY_W-1:0]   right_payload,
   output spq_pkg::cell_flag_type           flags,
   output logic [spq_pkg::KEY_W-1:0]        key_q,
   output logic [spq_pkg::PAY_W-1:0]        payload_q
);

   logic [spq_pkg::KEY_W-1:0] key_ff;
   logic [spq_pkg::KEY_W-1:0] key_in;
   logic [spq_pkg::PAY_W-1:0] payload_ff;
   logic [spq_pkg::PAY_W-1:0] payload_in;
   logic                      occupied;

   assign occupied = ({1'b0, cell_index} < occupancy);

   always_comb begin
      flags.after = occupied &&
                    (sort_descending ? (new_key < key_ff) : (new_key > key_ff));
      flags.equal = (key_ff == new_key);
   end

   // insert: the first cell whose key does not stay ahead takes the new
   // entry, every cell behind it takes its left neighbour
   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctrl.ins_en) begin
         if (!left_after) begin
            key_in     = left_key;
            payload_in = left_payload;
         end else if (!flags.after) begin
            key_in     = new_key;
            payload_in = new_payload;
         end
      end else if (ctrl.del_en && (cell_index >= ctrl.del_pos)) begin
         key_in     = right_key;
         payload_in = right_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key_q     = key_ff;
   assign payload_q = payload_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_core.sv
// Sorted priority queue: a chain of DEPTH cells kept in key order.
// The response becomes valid in the cycle after the request transfer.
// Throughput: one operation per cycle; a request is taken whenever the response
// register is empty or being drained in the same cycle, set by that register.
// Reset (synchronous, active high) empties the list and selects ascending order;
// cell contents are not cleared, only the occupancy count.
`default_nettype none

module sorted_priority_queue_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // configuration
   input  wire logic                         csr_wr_en,
   input  wire logic                         csr_wr_data,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [spq_pkg::OP_W-1:0]     req_operation,
   input  wire logic [spq_pkg::KEY_W-1:0]    req_key,
   input  wire logic [spq_pkg::PAY_W-1:0]    req_payload,
   input  wire logic [spq_pkg::IDX_W-1:0]    req_position,
   input  wire logic [spq_pkg::CNT_W-1:0]    req_range_end,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [spq_pkg::STAT_W-1:0]        rsp_status,
   output logic [spq_pkg::CNT_W-1:0]         rsp_index_out,
   output logic                              rsp_found,
   output logic [spq_pkg::CNT_W-1:0]         rsp_count,
   output logic                              rsp_is_empty,
   output logic [spq_pkg::KEY_W-1:0]         rsp_front_key,
   output logic [spq_pkg::PAY_W-1:0]         rsp_front_payload
);

   localparam int DEPTH = spq_pkg::DEPTH;

   // ---------------------------------------------------------------
   // state
   // ---------------------------------------------------------------
   logic                           sort_desc_ff;
   logic [spq_pkg::CNT_W-1:0]      occupancy_ff;
   logic [spq_pkg::CNT_W-1:0]      occupancy_in;

   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic [spq_pkg::STAT_W-1:0]     status_ff;
   logic [spq_pkg::STAT_W-1:0]     status_in;
   logic [spq_pkg::CNT_W-1:0]      index_ff;
   logic [spq_pkg::CNT_W-1:0]      index_in;
   logic                           found_ff;
   logic                           found_in;

   // ---------------------------------------------------------------
   // cell chain wiring
   // ---------------------------------------------------------------
   spq_pkg::cell_ctrl_type         ctrl;
   spq_pkg::cell_flag_type         flags     [DEPTH];
   logic [spq_pkg::KEY_W-1:0]      key_q     [DEPTH];
   logic [spq_pkg::PAY_W-1:0]      payload_q [DEPTH];
   logic [DEPTH-1:0]               after_vec;
   logic [DEPTH-1:0]               equal_vec;

   logic                           accept;
   logic                           is_empty;
   logic                           is_full;

   // insert position and find result
   logic [spq_pkg::CNT_W-1:0]      ins_idx;
   logic [spq_pkg::CNT_W-1:0]      find_idx;
   logic                           find_hit;
   logic                           find_bad;

   assign accept   = req_valid && req_ready;
   // the held response is either gone or leaving this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign is_empty = (occupancy_ff == '0);
   assign is_full  = (occupancy_ff == spq_pkg::CNT_W'(DEPTH));

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic                      left_after;
      logic [spq_pkg::KEY_W-1:0] left_key;
      logic [spq_pkg::PAY_W-1:0] left_payload;
      logic [spq_pkg::KEY_W-1:0] right_key;
      logic [spq_pkg::PAY_W-1:0] right_payload;

      if (g == 0) begin : g_head
         // nothing stands ahead of the head slot
         assign left_after   = 1'b1;
         assign left_key     = req_key;
         assign left_payload = req_payload;
      end else begin : g_body
         assign left_after   = flags[g-1].after;
         assign left_key     = key_q[g-1];
         assign left_payload = payload_q[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         // the tail slot falls out of use after a removal; keep its value
         assign right_key     = key_q[g];
         assign right_payload = payload_q[g];
      end else begin : g_inner
         assign right_key     = key_q[g+1];
         assign right_payload = payload_q[g+1];
      end

      spq_cell u_cell (
         .clock           (clock),
         .cell_index      (spq_pkg::IDX_W'(g)),
         .occupancy       (occupancy_ff),
         .sort_descending (sort_desc_ff),
         .ctrl            (ctrl),
         .left_after      (left_after),
         .new_key         (req_key),
         .new_payload     (req_payload),
         .left_key        (left_key),
         .left_payload    (left_payload),
         .right_key       (right_key),
         .right_payload   (right_payload),
         .flags           (flags[g]),
         .key_q           (key_q[g]),
         .payload_q       (payload_q[g])
      );

      assign after_vec[g] = flags[g].after;
      assign equal_vec[g] = flags[g].equal;
   end

   // ---------------------------------------------------------------
   // insert position: the after flags form a prefix over the occupied
   // slots, so the first clear flag marks the slot the new entry takes
   // ---------------------------------------------------------------
   always_comb begin
      ins_idx = spq_pkg::CNT_W'(DEPTH);
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (!after_vec[i]) begin
            ins_idx = spq_pkg::CNT_W'(i);
         end
      end
   end

   // ---------------------------------------------------------------
   // find: first equal key within [position, range_end)
   // ---------------------------------------------------------------
   always_comb begin
      find_idx = req_range_end;
      find_hit = 1'b0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (equal_vec[i] &&
             (spq_pkg::CNT_W'(i) >= {1'b0, req_position}) &&
             (spq_pkg::CNT_W'(i) < req_range_end)) begin
            find_idx = spq_pkg::CNT_W'(i);
            find_hit = 1'b1;
         end
      end
   end

   assign find_bad = ({1'b0, req_position} > req_range_end) ||
                     (req_range_end > occupancy_ff);

   // ---------------------------------------------------------------
   // operation decode: cell control, occupancy and result fields
   // ---------------------------------------------------------------
   always_comb begin
      ctrl         = '0;
      occupancy_in = occupancy_ff;
      status_in    = spq_pkg::ST_OK;
      index_in     = '0;
      found_in     = 1'b0;
      unique case (req_operation)
         spq_pkg::OP_INSERT: begin
            if (is_full) begin
               status_in = spq_pkg::ST_FULL;
            end else begin
               ctrl.ins_en  = accept;
               occupancy_in = occupancy_ff + spq_pkg::CNT_W'(1);
               index_in     = ins_idx;
            end
         end
         spq_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               ctrl.del_en  = accept;
               occupancy_in = occupancy_ff - spq_pkg::CNT_W'(1);
            end
         end
         spq_pkg::OP_POP_BACK: begin
            if (is_empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else begin
               occupancy_in = occupancy_ff - spq_pkg::CNT_W'(1);
            end
         end
         spq_pkg::OP_REMOVE: begin
            if (is_empty) begin
               status_in = spq_pkg::ST_EMPTY;
            end else if ({1'b0, req_position} >= occupancy_ff) begin
               status_in = spq_pkg::ST_RANGE;
            end else begin
               ctrl.del_en  = accept;
               ctrl.del_pos = req_position;
               occupancy_in = occupancy_ff - spq_pkg::CNT_W'(1);
               index_in     = {1'b0, req_position};
            end
         end
         spq_pkg::OP_FIND: begin
            if (find_bad) begin
               status_in = spq_pkg::ST_RANGE;
               index_in  = req_range_end;
            end else begin
               index_in = find_idx;
               found_in = find_hit;
            end
         end
         default: begin
            // unknown operation: list untouched, plain ok response
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sort_desc_ff <= 1'b0;
         occupancy_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sort_desc_ff <= csr_wr_data;
         end
         if (accept) begin
            occupancy_ff <= occupancy_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         found_ff  <= found_in;
      end
   end

   // ---------------------------------------------------------------
   // response: the list only changes on a transfer that also reloads the
   // response register, so count and head are read live from the chain
   // ---------------------------------------------------------------
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_index_out     = index_ff;
   assign rsp_found         = found_ff;
   assign rsp_count         = occupancy_ff;
   assign rsp_is_empty      = is_empty;
   assign rsp_front_key     = is_empty ? '0 : key_q[0];
   assign rsp_front_payload = is_empty ? '0 : payload_q[0];

endmodule

`default_nettype wire

FILE: rtl/core/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_core_macros.svh.
`default_nettype none

`include "sorted_priority_queue_core_macros.svh"

module spq_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic [spq_pkg::OP_W-1:0]     req_operation,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [spq_pkg::STAT_W-1:0]   rsp_status,
   input wire logic [spq_pkg::CNT_W-1:0]    rsp_index_out,
   input wire logic                         rsp_found,
   input wire logic [spq_pkg::CNT_W-1:0]    rsp_count,
   input wire logic                         rsp_is_empty,
   input wire logic [spq_pkg::KEY_W-1:0]    rsp_front_key,
   input wire logic [spq_pkg::PAY_W-1:0]    rsp_front_payload
);

   // a stalled response must not move
   `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_index_out) && $stable(rsp_found))

   // count never exceeds the list size
   `SPQ_ASSERT_NOW(a_count_bound, 1'b1, rsp_count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))

   // an empty list shows a zero head
   `SPQ_ASSERT_NOW(a_empty_head, rsp_is_empty, rsp_count == '0 && rsp_front_key == '0 && rsp_front_payload == '0)

   // insert into a full list is refused and leaves the count alone
   `SPQ_ASSERT_NEXT(a_full_insert, req_valid && req_ready && req_operation == spq_pkg::OP_INSERT && rsp_count == spq_pkg::CNT_W'(spq_pkg::DEPTH), rsp_valid && rsp_status == spq_pkg::ST_FULL && rsp_count == spq_pkg::CNT_W'(spq_pkg::DEPTH))

   // a find that reports a hit is always an ok result at an index inside the list
   `SPQ_ASSERT_NOW(a_found_ok, rsp_valid && rsp_found, rsp_status == spq_pkg::ST_OK && rsp_index_out < rsp_count)

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

`default_nettype wire

FILE: test/sorted_priority_queue_core_tb.sv
// Testbench for sorted_priority_queue_core: directed table, then random traffic in both key
// orders, each response checked against its typed row or a behavioural copy of the list.
// Depends on spq_pkg and the sorted_priority_queue_core RTL only.

module sorted_priority_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   // opcodes the block must ignore
   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_FIND + 3'd1;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;

   localparam int RANDOM_PER_PHASE = 284;
   localparam int QUIET_FIRST      = 350;   // random items run with no idling on either side
   localparam int QUIET_LAST       = 499;
   localparam int SETTLE_CYCLES    = 10;    // margin after the drain loop
   localparam int DRAIN_LIMIT      = 2000;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
      logic [IDX_W-1:0] position;
      logic [CNT_W-1:0] range_end;
   } request_t;

   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] index_out;
      logic             found;
      logic [CNT_W-1:0] count;
      logic             is_empty;
      logic [KEY_W-1:0] front_key;
      logic [PAY_W-1:0] front_payload;
   } response_t;

   // reps > 1 repeats the row with the key stepped by one each time
   typedef struct packed {
      request_t  req;
      logic [4:0] reps;
      logic       typed;
      response_t  rsp;
   } directed_row_t;

   localparam response_t EMPTY_RSP = '{ST_EMPTY, 5'd0, 1'b0, 5'd0, 1'b1, 32'h0, 32'h0};
   localparam response_t IDLE_RSP  = '{ST_OK, 5'd0, 1'b0, 5'd0, 1'b1, 32'h0, 32'h0};
   localparam response_t NONE_RSP  = '0;

   // Directed stimulus, ascending order. Typed rows carry an obvious answer; the rest go
   // through the shadow list.
   directed_row_t directed_rows [25] = '{
      // empty list: pops and removal flagged, find on an empty range is fine but not past the end, unused opcode ok
      '{'{OP_POP_FRONT, 32'h0, 32'h0, 4'd0, 5'd0}, 5'd1, 1'b1, EMPTY_RSP},
      '{'{OP_POP_BACK, 32'h0, 32'h0, 4'd0, 5'd0}, 5'd1, 1'b1, EMPTY_RSP},
      '{'{OP_REMOVE, 32'h0, 32'h0, 4'd15, 5'd0}, 5'd1, 1'b1, EMPTY_RSP},
      '{'{OP_FIND, 32'h0, 32'h0, 4'd0, 5'd0}, 5'd1, 1'b1, IDLE_RSP},
      '{'{OP_FIND, 32'hFFFF_FFFF, 32'h0, 4'd0, 5'd16}, 5'd1, 1'b1,
        '{ST_RANGE, 5'd16, 1'b0, 5'd0, 1'b1, 32'h0, 32'h0}},
      '{'{OP_UNUSED_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 5'd16}, 5'd1, 1'b1, IDLE_RSP},
      // key extremes
      '{'{OP_INSERT, 32'hFFFF_FFFF, 32'h0, 4'd0, 5'd0}, 5'd1, 1'b1,
        '{ST_OK, 5'd0, 1'b0, 5'd1, 1'b0, 32'hFFFF_FFFF, 32'h0}},
      '{'{OP_INSERT, 32'h0, 32'hFFFF_FFFF, 4'd15, 5'd16}, 5'd1, 1'b1,
        '{ST_OK, 5'd0, 1'b0, 5'd2, 1'b0, 32'h0, 32'hFFFF_FFFF}},
      // equal keys: the newer one lands in front
      '{'{OP_INSERT, 32'h8000_0000, 32'h5A5A_5A5A, 4'd0, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 4'd0, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      // find: first match, match past the start position, absent key, bad ranges
      '{'{OP_FIND, 32'h8000_0000, 32'h0, 4'd0, 5'd4}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_FIND, 32'h8000_0000, 32'h0, 4'd2, 5'd4}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_FIND, 32'h1234_5678, 32'h0, 4'd0, 5'd4}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_FIND, 32'h0, 32'h0, 4'd3, 5'd2}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_FIND, 32'h0, 32'h0, 4'd0, 5'd5}, 5'd1, 1'b0, NONE_RSP},
      // removal one past the end, then a good one, then both pops
      '{'{OP_REMOVE, 32'h0, 32'h0, 4'd4, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_REMOVE, 32'h0, 32'h0, 4'd1, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_POP_BACK, 32'h0, 32'h0, 4'd0, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_POP_FRONT, 32'h0, 32'h0, 4'd0, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      // fill to the brim, overfill, then work on a full list
      '{'{OP_INSERT, 32'h0000_0100, 32'hC0DE_0000, 4'd0, 5'd0}, 5'd15, 1'b0, NONE_RSP},
      '{'{OP_INSERT, 32'h0000_0200, 32'h1111_1111, 4'd0, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_FIND, 32'h0000_010E, 32'h0, 4'd0, 5'd16}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_FIND, 32'h0000_010E, 32'h0, 4'd15, 5'd16}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_REMOVE, 32'h0, 32'h0, 4'd15, 5'd0}, 5'd1, 1'b0, NONE_RSP},
      '{'{OP_POP_BACK, 32'h0, 32'h0, 4'd0, 5'd0}, 5'd1, 1'b0, NONE_RSP}
   };

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic             csr_wr_data;
   logic             req_valid;
   logic             req_ready;
   logic [OP_W-1:0]  req_operation;
   logic [KEY_W-1:0] req_key;
   logic [PAY_W-1:0] req_payload;
   logic [IDX_W-1:0] req_position;
   logic [CNT_W-1:0] req_range_end;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [CNT_W-1:0] rsp_index_out;
   logic             rsp_found;
   logic [CNT_W-1:0] rsp_count;
   logic             rsp_is_empty;
   logic [KEY_W-1:0] rsp_front_key;
   logic [PAY_W-1:0] rsp_front_payload;

   // shadow of the list contents and the order register
   logic [KEY_W-1:0] list_key     [DEPTH];
   logic [PAY_W-1:0] list_payload [DEPTH];
   int               held       = 0;
   bit               descending = 1'b0;

   response_t awaited_responses [$];
   int        failures = 0;
   bit        quiet    = 1'b0;   // suppresses idling on both sides

   sorted_priority_queue_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_key           (req_key),
      .req_payload       (req_payload),
      .req_position      (req_position),
      .req_range_end     (req_range_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_index_out     (rsp_index_out),
      .rsp_found         (rsp_found),
      .rsp_count         (rsp_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_front_key     (rsp_front_key),
      .rsp_front_payload (rsp_front_payload)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200_000;
      $display("Some tests failed");
      $finish;
   end

   // Applies one operation to the shadow list and returns the response it must produce.
   function automatic response_t sorted_list_step(request_t r);
      response_t res;
      int        slot;
      int        i;
      res = NONE_RSP;
      res.status = ST_OK;
      case (r.operation)
         OP_INSERT: begin
            if (held >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // first slot whose key does not sort strictly before the new one
               slot = 0;
               while (slot < held &&
                      (descending ? r.key < list_key[slot] : r.key > list_key[slot]))
                  slot++;
               for (i = held; i > slot; i--) begin
                  list_key[i]     = list_key[i-1];
                  list_payload[i] = list_payload[i-1];
               end
               list_key[slot]     = r.key;
               list_payload[slot] = r.payload;
               held++;
               res.index_out = CNT_W'(slot);
            end
         end
         OP_POP_FRONT, OP_REMOVE: begin
            if (held == 0) begin
               res.status = ST_EMPTY;
            end else if (r.operation == OP_REMOVE && int'(r.position) >= held) begin
               res.status = ST_RANGE;
            end else begin
               slot = (r.operation == OP_REMOVE) ? int'(r.position) : 0;
               for (i = slot; i + 1 < held; i++) begin
                  list_key[i]     = list_key[i+1];
                  list_payload[i] = list_payload[i+1];
               end
               held--;
               if (r.operation == OP_REMOVE)
                  res.index_out = CNT_W'(slot);
            end
         end
         OP_POP_BACK: begin
            if (held == 0)
               res.status = ST_EMPTY;
            else
               held--;
         end
         OP_FIND: begin
            res.index_out = r.range_end;
            if (r.position > r.range_end || int'(r.range_end) > held) begin
               res.status = ST_RANGE;
            end else begin
               for (i = r.position; i < int'(r.range_end); i++) begin
                  if (list_key[i] == r.key) begin
                     res.index_out = CNT_W'(i);
                     res.found     = 1'b1;
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      res.count         = CNT_W'(held);
      res.is_empty      = (held == 0);
      res.front_key     = held > 0 ? list_key[0] : '0;
      res.front_payload = held > 0 ? list_payload[0] : '0;
      return res;
   endfunction

   // Mostly well-formed traffic: keys often repeat or match held entries, positions and
   // ranges mostly valid. fill_bias leans towards inserts so the list reaches full.
   function automatic request_t random_request(bit fill_bias);
      request_t r;
      int       pick;
      pick      = $urandom_range(99);
      r.payload = $urandom;
      case ($urandom_range(3))
         0: r.key = KEY_W'($urandom_range(7));
         1: begin
            if (held > 0)
               r.key = list_key[$urandom_range(held - 1)];
            else
               r.key = $urandom;
         end
         2: r.key = $urandom;
         default: r.key = $urandom_range(1) ? '1 : '0;
      endcase

      if (pick < (fill_bias ? 55 : 25))
         r.operation = OP_INSERT;
      else if (pick < (fill_bias ? 63 : 45))
         r.operation = OP_POP_FRONT;
      else if (pick < (fill_bias ? 71 : 60))
         r.operation = OP_POP_BACK;
      else if (pick < (fill_bias ? 81 : 75))
         r.operation = OP_REMOVE;
      else if (pick < 96)
         r.operation = OP_FIND;
      else
         r.operation = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));

      if (held > 0 && $urandom_range(9) < 8)
         r.position = IDX_W'($urandom_range(held - 1));
      else
         r.position = IDX_W'($urandom_range(DEPTH - 1));
      r.range_end = CNT_W'($urandom_range(DEPTH));

      if (r.operation == OP_FIND && $urandom_range(3) != 0) begin
         r.range_end = CNT_W'($urandom_range(held));
         r.position  = IDX_W'($urandom_range(r.range_end >= DEPTH ? DEPTH - 1 : r.range_end));
      end
      return r;
   endfunction

   // Presents one request, holding it until the transfer, then books its response.
   task automatic send_request(input request_t r, input bit use_typed,
                               input response_t typed_rsp);
      response_t predicted;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= r.operation;
      req_key       <= r.key;
      req_payload   <= r.payload;
      req_position  <= r.position;
      req_range_end <= r.range_end;
      do @(posedge clock); while (!req_ready);
      predicted = sorted_list_step(r);
      awaited_responses.push_back(use_typed ? typed_rsp : predicted);
   endtask

   // Sender holds off until every booked response has come back.
   task automatic hold_until_answered();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0)
         @(negedge clock);
   endtask

   // Only called with nothing in flight; every request yields a response.
   task automatic write_sort_order(input bit value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      descending = value;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endtask

   // Receiver: random back-pressure, none during the quiet stretch.
   always @(negedge clock)
      rsp_ready <= quiet || ($urandom_range(99) >= 24);

   // Response checker: each transfer against the oldest booked response.
   always @(posedge clock) begin
      response_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: response with none expected, status %0h count %0h",
                     $time, rsp_status, rsp_count);
            failures++;
         end else begin
            want = awaited_responses.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_status));
            compare_field("index_out", 32'(want.index_out), 32'(rsp_index_out));
            compare_field("found", 32'(want.found), 32'(rsp_found));
            compare_field("count", 32'(want.count), 32'(rsp_count));
            compare_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
            compare_field("front_key", want.front_key, rsp_front_key);
            compare_field("front_payload", want.front_payload, rsp_front_payload);
         end
      end
   end

   initial begin
      request_t r;
      bit       orders [3];
      int       issued;
      int       n;
      orders        = '{1'b1, 1'b0, 1'b1};
      issued        = 0;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      req_valid     = 1'b0;
      req_operation = OP_INSERT;
      req_key       = '0;
      req_payload   = '0;
      req_position  = '0;
      req_range_end = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ascending order, written explicitly although reset already selects it
      write_sort_order(1'b0);

      foreach (directed_rows[i]) begin
         for (int k = 0; k < int'(directed_rows[i].reps); k++) begin
            r     = directed_rows[i].req;
            r.key = r.key + KEY_W'(k);
            send_request(r, directed_rows[i].typed, directed_rows[i].rsp);
         end
      end

      // Random phases. The list is emptied before every change of order so that
      // its contents always sit in the order the register names.
      foreach (orders[p]) begin
         while (held > 0) begin
            r           = random_request(1'b0);
            r.operation = OP_POP_FRONT;
            send_request(r, 1'b0, NONE_RSP);
         end
         hold_until_answered();
         write_sort_order(orders[p]);
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            quiet = (issued >= QUIET_FIRST && issued <= QUIET_LAST);
            send_request(random_request(((n / 64) % 2) == 0), 1'b0, NONE_RSP);
            issued++;
            // sender pause with the pipe fully drained
            if (n % 100 == 99)
               hold_until_answered();
         end
      end
      quiet = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      n = 0;
      while (awaited_responses.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, awaited_responses.size());
         failures += awaited_responses.size();
      end

      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
